[hdl/tlpg_pkg.sv]
package tlpg_pkg;

    localparam int CANVAS_WIDTH    = 1024;
    localparam int CANVAS_HEIGHT   = 768;
    localparam int BYTES_PER_PIXEL = 4;

    localparam int IN_W    = 12;
    localparam int COORD_W = 13;
    localparam int PIX_W   = 14;
    localparam int ERR_W   = 14;
    localparam int HALF_W  = 6;
    localparam int SIDE_W  = HALF_W + 1;
    localparam int PXO_W   = 10;
    localparam int ADDR_W  = 22;
    localparam int RGBA_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int QUEUE_AW   = 1;

    localparam logic [HALF_W-1:0] MAX_HALF = HALF_W'(32);

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_HALF_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ALPHA     = 3'd4;

    typedef struct packed {
        logic                    cmd;
        logic signed [IN_W-1:0]  start_x;
        logic signed [IN_W-1:0]  start_y;
        logic signed [IN_W-1:0]  end_x;
        logic signed [IN_W-1:0]  end_y;
    } in_item_t;

    typedef struct packed {
        logic                    pixel_valid;
        logic [PXO_W-1:0]        pixel_x;
        logic [PXO_W-1:0]        pixel_y;
        logic [ADDR_W-1:0]       byte_address;
        logic [RGBA_W-1:0]       pixel_rgba;
        logic                    line_done;
        logic                    clipped;
    } out_item_t;

    // decoded item as it sits in the queue
    typedef struct packed {
        logic                    cmd;
        logic signed [IN_W-1:0]  cur_x;
        logic signed [IN_W-1:0]  cur_y;
        logic signed [IN_W-1:0]  tgt_x;
        logic signed [IN_W-1:0]  tgt_y;
        logic [IN_W-1:0]         span_x;
        logic [IN_W-1:0]         span_y;
        logic                    dir_x_neg;
        logic                    dir_y_neg;
        logic signed [ERR_W-1:0] err;
    } seg_item_t;

    typedef struct packed {
        logic [HALF_W-1:0]       half_size;
        logic [RGBA_W-1:0]       rgba;
    } cfg_t;

    function automatic logic off_canvas(input logic signed [PIX_W-1:0] x,
                                        input logic signed [PIX_W-1:0] y);
        logic signed [PIX_W-1:0] xmax;
        logic signed [PIX_W-1:0] ymax;
        xmax = PIX_W'(CANVAS_WIDTH - 1);
        ymax = PIX_W'(CANVAS_HEIGHT - 1);
        return (x < 0) || (x > xmax) || (y < 0) || (y > ymax);
    endfunction

endpackage

[hdl/tlpg_front.sv]
module tlpg_front
    import tlpg_pkg::*;
(
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      push,
    output seg_item_t seg,
    input  logic      queue_full
);

    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [IN_W-1:0]           sx;
    logic [IN_W-1:0]           sy;

    assign item_ready = !queue_full;
    assign push       = item_valid && !queue_full;

    always_comb
    begin
        dx = COORD_W'(item.end_x) - COORD_W'(item.start_x);
        dy = COORD_W'(item.end_y) - COORD_W'(item.start_y);
        sx = (dx < 0) ? IN_W'(-dx) : IN_W'(dx);
        sy = (dy < 0) ? IN_W'(-dy) : IN_W'(dy);

        seg.cmd       = item.cmd;
        seg.cur_x     = item.start_x;
        seg.cur_y     = item.start_y;
        seg.tgt_x     = item.end_x;
        seg.tgt_y     = item.end_y;
        seg.span_x    = sx;
        seg.span_y    = sy;
        seg.dir_x_neg = !(item.start_x < item.end_x);
        seg.dir_y_neg = !(item.start_y < item.end_y);
        // halve toward zero on both signs
        if (sx > sy)
        begin
            seg.err = $signed(ERR_W'(sx >> 1));
        end
        else
        begin
            seg.err = -$signed(ERR_W'(sy >> 1));
        end
    end

endmodule

[hdl/tlpg_queue.sv]
module tlpg_queue
    import tlpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  seg_item_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output seg_item_t pop_data
);

    localparam int DEPTH = 1 << QUEUE_AW;

    seg_item_t           mem [DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

[hdl/tlpg_back.sv]
module tlpg_back
    import tlpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      queue_not_empty,
    input  seg_item_t seg,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic                      busy_reg,  busy_next;
    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_W-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_W-1:0] tgt_x_reg, tgt_x_next;
    logic signed [COORD_W-1:0] tgt_y_reg, tgt_y_next;
    logic [COORD_W-1:0]        span_x_reg, span_x_next;
    logic [COORD_W-1:0]        span_y_reg, span_y_next;
    logic                      dneg_x_reg, dneg_x_next;
    logic                      dneg_y_reg, dneg_y_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [HALF_W-1:0]         col_reg, col_next;
    logic [HALF_W-1:0]         row_reg, row_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;

    logic [HALF_W-1:0]         half;
    logic [SIDE_W-1:0]         side;
    logic [SIDE_W-1:0]         row_inc;
    logic [SIDE_W-1:0]         col_inc;
    logic signed [PIX_W-1:0]   px;
    logic signed [PIX_W-1:0]   py;
    logic signed [ERR_W-1:0]   sx_s;
    logic signed [ERR_W-1:0]   sy_s;
    logic                      at_target;
    logic                      cur_off;
    logic                      step_x;
    logic                      step_y;
    logic signed [COORD_W-1:0] mv_x;
    logic signed [COORD_W-1:0] mv_y;
    logic signed [ERR_W-1:0]   mv_err;
    logic [31:0]               lin;

    assign pop          = queue_not_empty && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // end test and one walk step, shared by both stamp-done paths
    always_comb
    begin
        half    = (cfg.half_size > MAX_HALF) ? MAX_HALF : cfg.half_size;
        side    = {half, 1'b0};
        row_inc = {1'b0, row_reg} + 1'b1;
        col_inc = {1'b0, col_reg} + 1'b1;
        px      = PIX_W'(cur_x_reg) + $signed(PIX_W'(col_reg));
        py      = PIX_W'(cur_y_reg) + $signed(PIX_W'(row_reg));
        sx_s    = $signed(ERR_W'(span_x_reg));
        sy_s    = $signed(ERR_W'(span_y_reg));

        at_target = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
        cur_off   = off_canvas(PIX_W'(cur_x_reg), PIX_W'(cur_y_reg));
        step_x    = err_reg > -sx_s;
        step_y    = err_reg < sy_s;
        mv_err    = err_reg;
        mv_x      = cur_x_reg;
        mv_y      = cur_y_reg;
        if (step_x)
        begin
            mv_err = mv_err - sy_s;
            mv_x   = dneg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        end
        if (step_y)
        begin
            mv_err = mv_err + sx_s;
            mv_y   = dneg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        end

        lin = 32'(px[PIX_W-2:0]) + 32'(py[PIX_W-2:0]) * 32'(CANVAS_WIDTH);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        dneg_x_next    = dneg_x_reg;
        dneg_y_next    = dneg_y_reg;
        err_next       = err_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;

        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (seg.cmd == CMD_START)
            begin
                busy_next   = 1'b1;
                cur_x_next  = COORD_W'(seg.cur_x);
                cur_y_next  = COORD_W'(seg.cur_y);
                tgt_x_next  = COORD_W'(seg.tgt_x);
                tgt_y_next  = COORD_W'(seg.tgt_y);
                span_x_next = COORD_W'(seg.span_x);
                span_y_next = COORD_W'(seg.span_y);
                dneg_x_next = seg.dir_x_neg;
                dneg_y_next = seg.dir_y_neg;
                err_next    = seg.err;
                col_next    = '0;
                row_next    = '0;
            end
            else if (!busy_reg)
            begin
                out_next.line_done = 1'b1;
            end
            else if (side == '0)
            begin
                // empty brush: only the end test and the move
                if (at_target || cur_off)
                begin
                    busy_next          = 1'b0;
                    out_next.line_done = 1'b1;
                    out_next.clipped   = !at_target;
                end
                else
                begin
                    cur_x_next = mv_x;
                    cur_y_next = mv_y;
                    err_next   = mv_err;
                end
            end
            else if (off_canvas(px, py))
            begin
                busy_next          = 1'b0;
                col_next           = '0;
                row_next           = '0;
                out_next.line_done = 1'b1;
                out_next.clipped   = 1'b1;
            end
            else
            begin
                out_next.pixel_valid  = 1'b1;
                out_next.pixel_x      = PXO_W'(px);
                out_next.pixel_y      = PXO_W'(py);
                out_next.byte_address = ADDR_W'(lin * 32'(BYTES_PER_PIXEL));
                out_next.pixel_rgba   = cfg.rgba;
                row_next              = HALF_W'(row_inc);
                if (row_inc >= side)
                begin
                    row_next = '0;
                    col_next = HALF_W'(col_inc);
                    if (col_inc >= side)
                    begin
                        col_next = '0;
                        if (at_target || cur_off)
                        begin
                            busy_next          = 1'b0;
                            out_next.line_done = 1'b1;
                            out_next.clipped   = !at_target;
                        end
                        else
                        begin
                            cur_x_next = mv_x;
                            cur_y_next = mv_y;
                            err_next   = mv_err;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            dneg_x_reg    <= 1'b0;
            dneg_y_reg    <= 1'b0;
            err_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            dneg_x_reg    <= dneg_x_next;
            dneg_y_reg    <= dneg_y_next;
            err_reg       <= err_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/thick_line_pixel_generator_top.sv]
// Thick line pixel generator: walks a line between two endpoints and stamps
// a square brush at every point, at most one brush pixel per advance item.
// Input channel (item_valid/item_ready/item): cmd start loads the endpoints,
// cmd advance produces the next brush pixel or a step. Every item gives exactly one
// result on the output channel (result_valid/result_ready/result).
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 brush half size, 1..4 red, green, blue, alpha); change it only while
// no items are in flight.
// Path: an accepted item is written into the queue and popped by the back end
// when the result register is empty or being read; its result is then held
// in the result register until taken.
// Throughput: one item per clock while result_ready stays high; a two-entry
// queue sits between decode and execute in the back end.
// When the receiver stalls, the result register holds, the queue fills up
// to its two entries and item_ready drops until the result is taken.
// Reset: queue empty, no result pending, line idle, brush half size 1 and
// all color bytes 255.
module thick_line_pixel_generator_top
    import tlpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [HALF_W-1:0]     half_reg;
    logic [CFG_DATA_W-1:0] red_reg;
    logic [CFG_DATA_W-1:0] green_reg;
    logic [CFG_DATA_W-1:0] blue_reg;
    logic [CFG_DATA_W-1:0] alpha_reg;
    cfg_t                  cfg;

    logic      push;
    seg_item_t seg_in;
    seg_item_t seg_out;
    logic      queue_full;
    logic      queue_not_empty;
    logic      pop;

    assign cfg.half_size = half_reg;
    assign cfg.rgba      = {red_reg, green_reg, blue_reg, alpha_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= HALF_W'(1);
            red_reg   <= '1;
            green_reg <= '1;
            blue_reg  <= '1;
            alpha_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BRUSH_HALF_SIZE: half_reg  <= HALF_W'(cfg_data);
                REG_COLOR_RED:       red_reg   <= cfg_data;
                REG_COLOR_GREEN:     green_reg <= cfg_data;
                REG_COLOR_BLUE:      blue_reg  <= cfg_data;
                REG_COLOR_ALPHA:     alpha_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    tlpg_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .seg        (seg_in),
        .queue_full (queue_full)
    );

    tlpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (seg_in),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (seg_out)
    );

    tlpg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .queue_not_empty (queue_not_empty),
        .seg             (seg_out),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result)
    );

endmodule

[hdl/tlpg_checker.sv]
module tlpg_checker
    import tlpg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // no pixel means zeroed pixel fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.pixel_valid |->
            result.pixel_x == '0 && result.pixel_y == '0 &&
            result.byte_address == '0 && result.pixel_rgba == '0)
        else $error("pixel fields set without a pixel");

    // a clip always ends the line
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.clipped |-> result.line_done)
        else $error("clip without line end");

    // written pixels land on the canvas
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pixel_valid |->
            32'(result.pixel_x) < CANVAS_WIDTH &&
            32'(result.pixel_y) < CANVAS_HEIGHT)
        else $error("pixel outside canvas");

endmodule

bind thick_line_pixel_generator_top tlpg_checker u_tlpg_checker (.*);

[dv/thick_line_pixel_generator_top_test.sv]
module thick_line_pixel_generator_top_test;
    import tlpg_pkg::*;

    localparam int MAX_WAIT    = 13;
    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;
    localparam int FULL_TRACE  = 400;

    typedef enum int {WALK_ON, WALK_DONE, WALK_CLIPPED} walk_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    in_item_t              item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BRUSH_HALF_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // line walker state as predicted from the accepted items
    logic [HALF_W-1:0] brush_half = HALF_W'(1);
    logic [RGBA_W-1:0] paint_rgba = '1;
    bit                line_active = 1'b0;
    int                pen_x = 0;
    int                pen_y = 0;
    int                goal_x = 0;
    int                goal_y = 0;
    int                run_x = 0;
    int                run_y = 0;
    bit                step_x_neg = 1'b0;
    bit                step_y_neg = 1'b0;
    int                walk_err = 0;
    int                brush_u = 0;
    int                brush_v = 0;

    out_item_t         pixel_queue[$];
    int                items_sent = 0;
    int                results_seen = 0;
    int                mismatch_count = 0;
    int                sender_gap_max = MAX_WAIT;
    int                receiver_stall_max = MAX_WAIT;
    int                quiet_cycles = 0;

    thick_line_pixel_generator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic bit beyond_canvas(input int x, input int y);
        return x < 0 || x > CANVAS_WIDTH - 1 || y < 0 || y > CANVAS_HEIGHT - 1;
    endfunction

    function automatic out_item_t make_result(input bit valid, input int x, input int y,
                                              input bit done, input bit clip);
        out_item_t r;
        r = '0;
        if (valid)
        begin
            r.pixel_valid  = 1'b1;
            r.pixel_x      = x[PXO_W-1:0];
            r.pixel_y      = y[PXO_W-1:0];
            r.byte_address = ADDR_W'((x + y * CANVAS_WIDTH) * BYTES_PER_PIXEL);
            r.pixel_rgba   = paint_rgba;
        end
        r.line_done = done;
        r.clipped   = clip;
        return r;
    endfunction

    // end test, then one bresenham step once the stamp is complete
    function automatic walk_e end_or_move();
        int e2;
        if (pen_x == goal_x && pen_y == goal_y)
        begin
            line_active = 1'b0;
            return WALK_DONE;
        end
        if (beyond_canvas(pen_x, pen_y))
        begin
            line_active = 1'b0;
            return WALK_CLIPPED;
        end
        e2 = walk_err;
        if (e2 > -run_x)
        begin
            walk_err -= run_y;
            pen_x += step_x_neg ? -1 : 1;
        end
        if (e2 < run_y)
        begin
            walk_err += run_x;
            pen_y += step_y_neg ? -1 : 1;
        end
        return WALK_ON;
    endfunction

    task automatic predict_pixel(input in_item_t it);
        int    side;
        int    px;
        int    py;
        walk_e walk;
        side = 2 * int'((brush_half > MAX_HALF) ? MAX_HALF : brush_half);
        if (it.cmd == CMD_START)
        begin
            pen_x       = it.start_x;
            pen_y       = it.start_y;
            goal_x      = it.end_x;
            goal_y      = it.end_y;
            run_x       = (goal_x > pen_x) ? goal_x - pen_x : pen_x - goal_x;
            run_y       = (goal_y > pen_y) ? goal_y - pen_y : pen_y - goal_y;
            step_x_neg  = !(pen_x < goal_x);
            step_y_neg  = !(pen_y < goal_y);
            walk_err    = ((run_x > run_y) ? run_x : -run_y) / 2;
            brush_u     = 0;
            brush_v     = 0;
            line_active = 1'b1;
            pixel_queue.push_back(make_result(1'b0, 0, 0, 1'b0, 1'b0));
        end
        else if (!line_active)
        begin
            pixel_queue.push_back(make_result(1'b0, 0, 0, 1'b1, 1'b0));
        end
        else if (side == 0)
        begin
            walk = end_or_move();
            pixel_queue.push_back(make_result(1'b0, 0, 0, walk != WALK_ON,
                                              walk == WALK_CLIPPED));
        end
        else
        begin
            px = pen_x + brush_u;
            py = pen_y + brush_v;
            if (beyond_canvas(px, py))
            begin
                line_active = 1'b0;
                brush_u     = 0;
                brush_v     = 0;
                pixel_queue.push_back(make_result(1'b0, 0, 0, 1'b1, 1'b1));
            end
            else
            begin
                walk = WALK_ON;
                // row offset moves fastest
                brush_v++;
                if (brush_v >= side)
                begin
                    brush_v = 0;
                    brush_u++;
                    if (brush_u >= side)
                    begin
                        brush_u = 0;
                        walk    = end_or_move();
                    end
                end
                pixel_queue.push_back(make_result(1'b1, px, py, walk != WALK_ON,
                                                  walk == WALK_CLIPPED));
            end
        end
    endtask

    task automatic send_item(input in_item_t it);
        int gap;
        gap = $urandom_range(sender_gap_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        predict_pixel(it);
        items_sent++;
    endtask

    task automatic start_segment(input int x1, input int y1, input int x2, input int y2);
        in_item_t it;
        it.cmd     = CMD_START;
        it.start_x = IN_W'(x1);
        it.start_y = IN_W'(y1);
        it.end_x   = IN_W'(x2);
        it.end_y   = IN_W'(y2);
        send_item(it);
    endtask

    // endpoint fields carry junk on an advance item
    task automatic send_advance();
        in_item_t it;
        it.cmd     = CMD_ADVANCE;
        it.start_x = IN_W'($urandom);
        it.start_y = IN_W'($urandom);
        it.end_x   = IN_W'($urandom);
        it.end_y   = IN_W'($urandom);
        send_item(it);
    endtask

    task automatic trace_line(input int max_adv);
        int n;
        n = 0;
        while (line_active && n < max_adv)
        begin
            send_advance();
            n++;
        end
    endtask

    task automatic drain_pixels();
        item_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] half, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue,
                              input logic [7:0] alpha);
        logic [CFG_IDX_W-1:0]  regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        int                    i;
        regs = '{REG_BRUSH_HALF_SIZE, REG_COLOR_RED, REG_COLOR_GREEN, REG_COLOR_BLUE,
                 REG_COLOR_ALPHA};
        vals = '{half, red, green, blue, alpha};
        for (i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        brush_half = half[HALF_W-1:0];
        paint_rgba = {red, green, blue, alpha};
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("pixel result %0d: %s expected %0h got %0h", results_seen, name,
                         want, got);
        end
    endtask

    task automatic random_segment(input int side);
        int kind;
        int x1;
        int y1;
        int x2;
        int y2;
        int xmax;
        int ymax;
        xmax = CANVAS_WIDTH - ((side > 0) ? side : 1);
        ymax = CANVAS_HEIGHT - ((side > 0) ? side : 1);
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            // short on-canvas line, sometimes abandoned partway
            x1 = rand_between(0, xmax);
            y1 = rand_between(0, ymax);
            x2 = clamp(x1 + rand_between(-9, 9), 0, xmax);
            y2 = clamp(y1 + rand_between(-9, 9), 0, ymax);
            start_segment(x1, y1, x2, y2);
            trace_line(($urandom_range(4) == 0) ? rand_between(1, 12) : FULL_TRACE);
        end
        else if (kind < 85)
        begin
            // near an edge, often running off the canvas
            x1 = $urandom_range(1) ? rand_between(-2, 4) : rand_between(xmax - 2, CANVAS_WIDTH + 1);
            y1 = $urandom_range(1) ? rand_between(-2, 4) : rand_between(ymax - 2, CANVAS_HEIGHT + 1);
            x2 = x1 + rand_between(-8, 8);
            y2 = y1 + rand_between(-8, 8);
            start_segment(x1, y1, x2, y2);
            trace_line(FULL_TRACE);
        end
        else if (kind < 93)
        begin
            start_segment(rand_between(-2048, 2047), rand_between(-2048, 2047),
                          rand_between(-2048, 2047), rand_between(-2048, 2047));
            trace_line(rand_between(0, 3));
        end
        else
        begin
            send_advance();
        end
    endtask

    task automatic test_directed_cases();
        sender_gap_max     = MAX_WAIT;
        receiver_stall_max = MAX_WAIT;
        // reset settings: brush half 1, white
        send_advance();
        start_segment(5, 5, 5, 5);
        trace_line(10);
        start_segment(CANVAS_WIDTH - 1, CANVAS_HEIGHT - 1, 0, 0);
        trace_line(10);
        start_segment(-2048, 2047, 2047, -2048);
        trace_line(10);
        drain_pixels();
        // empty brush: only end test and move
        set_config(8'd0, 8'h00, 8'hFF, 8'h00, 8'hFF);
        start_segment(0, 0, 1, 3);
        trace_line(10);
        start_segment(3, 3, 1, 0);
        send_advance();
        // restart while busy, from off the canvas
        start_segment(-5, -5, -3, -3);
        trace_line(10);
        drain_pixels();
        set_config(8'd1, 8'hFF, 8'h00, 8'hFF, 8'h00);
        start_segment(20, 20, 20, 20);
        trace_line(10);
    endtask

    task automatic test_random_lines();
        int halves [10];
        int phase;
        int quota_end;
        int side;
        bit paused;
        halves = '{2, 3, 0, 1, 4, 1, 2, 0, 6, 1};
        for (phase = 0; phase < 10; phase++)
        begin
            drain_pixels();
            case (phase % 4)
                0: begin sender_gap_max = 0;        receiver_stall_max = 0;        end
                1: begin sender_gap_max = MAX_WAIT; receiver_stall_max = MAX_WAIT; end
                2: begin sender_gap_max = MAX_WAIT; receiver_stall_max = 0;        end
                default: begin sender_gap_max = 0;  receiver_stall_max = MAX_WAIT; end
            endcase
            if (phase == 1)
                set_config(8'(halves[phase]), 8'h00, 8'h00, 8'h00, 8'h00);
            else if (phase == 9)
                set_config(8'(halves[phase]), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            else
                set_config(8'(halves[phase]), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
            side      = 2 * halves[phase];
            quota_end = items_sent + 80;
            paused    = 1'b0;
            while (items_sent < quota_end)
            begin
                random_segment(side);
                // sender holds off until every pixel is back
                if (phase == 5 && !paused && items_sent > quota_end - 60)
                begin
                    drain_pixels();
                    paused = 1'b1;
                end
            end
        end
    endtask

    task automatic test_large_brush();
        drain_pixels();
        sender_gap_max     = MAX_WAIT;
        receiver_stall_max = MAX_WAIT;
        // half size above the cap is held at 32
        set_config(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        start_segment(CANVAS_WIDTH - 4, 700, CANVAS_WIDTH - 1, CANVAS_HEIGHT - 1);
        trace_line(5000);
        drain_pixels();
        set_config(8'd32, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        start_segment(1000, 740, 990, CANVAS_HEIGHT - 1);
        trace_line(5000);
    endtask

    initial
    begin : result_checker
        out_item_t want;
        int        stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(receiver_stall_max);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            results_seen++;
            if (pixel_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("pixel result %0d arrived with nothing expected: %p",
                             results_seen, result);
            end
            else
            begin
                want = pixel_queue.pop_front();
                check_field("pixel_valid", want.pixel_valid, result.pixel_valid);
                check_field("pixel_x", want.pixel_x, result.pixel_x);
                check_field("pixel_y", want.pixel_y, result.pixel_y);
                check_field("byte_address", want.byte_address, result.byte_address);
                check_field("pixel_rgba", want.pixel_rgba, result.pixel_rgba);
                check_field("line_done", want.line_done, result.line_done);
                check_field("clipped", want.clipped, result.clipped);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : main_sequence
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_lines();
        test_large_brush();
        drain_pixels();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pixel_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
hdl/tlpg_pkg.sv
hdl/tlpg_front.sv
hdl/tlpg_queue.sv
hdl/tlpg_back.sv
hdl/thick_line_pixel_generator_top.sv
hdl/tlpg_checker.sv
dv/thick_line_pixel_generator_top_test.sv
